### rtl/core/rlsm_pkg.sv
// rlsm_pkg: shared types and constants of the radio link sequence monitor
`default_nettype none

package rlsm_pkg;

  // register indexes on the configuration port
  localparam int unsigned CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_FAILSAFE_TIMEOUT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COMMAND_PERIOD   = 2'd1;

  // register reset values
  localparam logic [15:0] FAILSAFE_TIMEOUT_RESET = 16'd200;
  localparam logic [7:0]  COMMAND_PERIOD_RESET   = 8'd20;

  // request kinds
  localparam logic MODE_TICK  = 1'b0;
  localparam logic MODE_FRAME = 1'b1;

  // saturation limits
  localparam logic [3:0]  QUALITY_MAX = 4'd15;
  localparam logic [7:0]  AGE_OUT_MAX = 8'd255;
  localparam logic [15:0] COUNT_MAX   = 16'hFFFF;

  typedef struct packed {
    logic [15:0] failsafe_timeout_ms;
    logic [7:0]  command_period_ms;
  } cfg_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] seq;
  } item_t;

  typedef struct packed {
    logic        link_up;
    logic [3:0]  quality_level;
    logic [7:0]  frame_age_ms;
    logic        was_duplicate;
    logic [15:0] dropped_total;
    logic [15:0] duplicate_total;
    logic [15:0] resync_total;
    logic        slot_tick;
  } result_t;

endpackage

`default_nettype wire

### rtl/core/rlsm_tracker.sv
// rlsm_tracker: link state, sequence checks and quality window, one request per cycle in which fire is high
`default_nettype none

module rlsm_tracker #(
  parameter int unsigned WINDOW_SLOTS = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             fire,
  input  wire rlsm_pkg::item_t  item,
  input  wire rlsm_pkg::cfg_t   cfg,
  output rlsm_pkg::result_t     res
);

  localparam int unsigned CNT_W = $clog2(WINDOW_SLOTS + 1);

  logic [7:0]              last_sequence;
  logic                    sequence_seen;
  logic                    frame_seen;
  logic [15:0]             age_counter;
  logic [7:0]              slot_counter;
  logic [WINDOW_SLOTS-1:0] slot_window;
  logic [CNT_W-1:0]        ones_count;
  logic [15:0]             dropped_counter;
  logic [15:0]             duplicate_counter;
  logic [15:0]             resync_counter;

  logic [7:0]              last_sequence_next;
  logic                    sequence_seen_next;
  logic                    frame_seen_next;
  logic [15:0]             age_counter_next;
  logic [7:0]              slot_counter_next;
  logic [WINDOW_SLOTS-1:0] slot_window_next;
  logic [CNT_W-1:0]        ones_count_next;
  logic [15:0]             dropped_counter_next;
  logic [15:0]             duplicate_counter_next;
  logic [15:0]             resync_counter_next;

  logic        was_up;
  logic        up_after;
  logic [7:0]  period;
  logic [7:0]  slot_inc;
  logic        slot_hit;
  logic [7:0]  gap;
  logic [7:0]  gap_m1;
  logic [16:0] drop_sum;
  logic        shift_en;
  logic        shift_bit;
  logic        dup;
  logic [7:0]  quality_wide;

  // link state before this request
  assign was_up = frame_seen && (age_counter < cfg.failsafe_timeout_ms);

  // slot timing, a zero period acts as one
  assign period   = (cfg.command_period_ms == 8'd0) ? 8'd1 : cfg.command_period_ms;
  assign slot_inc = slot_counter + 8'd1;
  assign slot_hit = (slot_inc >= period);

  // wrap-safe sequence gap and the drop total it implies
  assign gap      = item.seq - last_sequence;
  assign gap_m1   = gap - 8'd1;
  assign drop_sum = {1'b0, dropped_counter} + {9'd0, gap_m1};

  // next state for one request
  always_comb begin
    last_sequence_next     = last_sequence;
    sequence_seen_next     = sequence_seen;
    frame_seen_next        = frame_seen;
    age_counter_next       = age_counter;
    slot_counter_next      = slot_counter;
    dropped_counter_next   = dropped_counter;
    duplicate_counter_next = duplicate_counter;
    resync_counter_next    = resync_counter;
    shift_en               = 1'b0;
    shift_bit              = 1'b0;
    dup                    = 1'b0;
    if (item.mode == rlsm_pkg::MODE_TICK) begin
      if (age_counter != rlsm_pkg::COUNT_MAX) begin
        age_counter_next = age_counter + 16'd1;
      end
      slot_counter_next = slot_hit ? 8'd0 : slot_inc;
      // an empty slot only counts while the link is down
      if (slot_hit && !(frame_seen && (age_counter_next < cfg.failsafe_timeout_ms))) begin
        shift_en = 1'b1;
      end
    end else begin
      age_counter_next = 16'd0;
      frame_seen_next  = 1'b1;
      shift_en         = 1'b1;
      shift_bit        = 1'b1;
      if (!sequence_seen) begin
        last_sequence_next = item.seq;
        sequence_seen_next = 1'b1;
      end else if (!was_up) begin
        // link came back: take a new baseline
        last_sequence_next = item.seq;
        if (resync_counter != rlsm_pkg::COUNT_MAX) begin
          resync_counter_next = resync_counter + 16'd1;
        end
      end else if (gap == 8'd0) begin
        dup = 1'b1;
        if (duplicate_counter != rlsm_pkg::COUNT_MAX) begin
          duplicate_counter_next = duplicate_counter + 16'd1;
        end
      end else begin
        last_sequence_next   = item.seq;
        dropped_counter_next = drop_sum[16] ? rlsm_pkg::COUNT_MAX : drop_sum[15:0];
      end
    end
  end

  // quality window with a running count of ones
  always_comb begin
    slot_window_next = slot_window;
    ones_count_next  = ones_count;
    if (shift_en) begin
      slot_window_next = {slot_window[WINDOW_SLOTS-2:0], shift_bit};
      ones_count_next  = ones_count + CNT_W'(shift_bit) - CNT_W'(slot_window[WINDOW_SLOTS-1]);
    end
  end

  // result of this request
  assign up_after     = frame_seen_next && (age_counter_next < cfg.failsafe_timeout_ms);
  assign quality_wide = 8'(ones_count_next);

  always_comb begin
    res.link_up         = up_after;
    res.quality_level   = (quality_wide > {4'd0, rlsm_pkg::QUALITY_MAX}) ?
                          rlsm_pkg::QUALITY_MAX : quality_wide[3:0];
    res.frame_age_ms    = (age_counter_next > {8'd0, rlsm_pkg::AGE_OUT_MAX}) ?
                          rlsm_pkg::AGE_OUT_MAX : age_counter_next[7:0];
    res.was_duplicate   = dup;
    res.dropped_total   = dropped_counter_next;
    res.duplicate_total = duplicate_counter_next;
    res.resync_total    = resync_counter_next;
    res.slot_tick       = (item.mode == rlsm_pkg::MODE_TICK) && slot_hit;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      last_sequence     <= '0;
      sequence_seen     <= 1'b0;
      frame_seen        <= 1'b0;
      age_counter       <= '0;
      slot_counter      <= '0;
      slot_window       <= '0;
      ones_count        <= '0;
      dropped_counter   <= '0;
      duplicate_counter <= '0;
      resync_counter    <= '0;
    end else if (fire) begin
      last_sequence     <= last_sequence_next;
      sequence_seen     <= sequence_seen_next;
      frame_seen        <= frame_seen_next;
      age_counter       <= age_counter_next;
      slot_counter      <= slot_counter_next;
      slot_window       <= slot_window_next;
      ones_count        <= ones_count_next;
      dropped_counter   <= dropped_counter_next;
      duplicate_counter <= duplicate_counter_next;
      resync_counter    <= resync_counter_next;
    end
  end

  // running count tracks the window contents
  assert property (@(posedge clk) disable iff (rst)
    ones_count == CNT_W'($countones(slot_window)))
    else $error("quality count out of step with window");

  // a baseline exists only after a frame
  assert property (@(posedge clk) disable iff (rst)
    sequence_seen |-> frame_seen)
    else $error("baseline set without a frame");

  // a frame clears the age
  assert property (@(posedge clk) disable iff (rst)
    fire && (item.mode == rlsm_pkg::MODE_FRAME) |=> (age_counter == 16'd0) && frame_seen)
    else $error("frame did not restart the age");

  // a result is never both a slot and a duplicate
  assert property (@(posedge clk) disable iff (rst)
    fire |-> !(res.slot_tick && res.was_duplicate))
    else $error("slot and duplicate flagged together");

endmodule

`default_nettype wire

### rtl/core/radio_link_sequence_monitor.sv
// radio_link_sequence_monitor: top level with request and result registers
// Path: an accepted request is captured in the request register, passes the tracker
// and is loaded into the result register once the result stage is free.
// Throughput: one request per cycle when out_stall is low, set by the single-pass update.
// Reset: synchronous rst clears all counters, the window and the link state,
// and loads a failsafe timeout of 200 ms and a command period of 20 ms.
`default_nettype none

module radio_link_sequence_monitor #(
  parameter int unsigned WINDOW_SLOTS = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // configuration port
  input  wire logic                             cfg_write,
  input  wire logic [rlsm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [15:0]                      cfg_data,
  // request channel
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             mode,
  input  wire logic [7:0]                       seq,
  // result channel
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic                                  link_up,
  output logic [3:0]                            quality_level,
  output logic [7:0]                            frame_age_ms,
  output logic                                  was_duplicate,
  output logic [15:0]                           dropped_total,
  output logic [15:0]                           duplicate_total,
  output logic [15:0]                           resync_total,
  output logic                                  slot_tick
);

  rlsm_pkg::cfg_t    cfg;
  rlsm_pkg::item_t   in_item;
  logic              in_item_valid;
  rlsm_pkg::result_t res_next;
  rlsm_pkg::result_t res;
  logic              out_free;
  logic              fire;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.failsafe_timeout_ms <= rlsm_pkg::FAILSAFE_TIMEOUT_RESET;
      cfg.command_period_ms   <= rlsm_pkg::COMMAND_PERIOD_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        rlsm_pkg::REG_FAILSAFE_TIMEOUT: cfg.failsafe_timeout_ms <= cfg_data;
        rlsm_pkg::REG_COMMAND_PERIOD:   cfg.command_period_ms   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // handshake between the two register stages
  assign out_free = !out_valid || !out_stall;
  assign fire     = in_item_valid && out_free;
  assign in_stall = in_item_valid && !out_free;

  // request register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_item_valid <= 1'b0;
    end else if (!in_stall) begin
      in_item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item.mode <= mode;
      in_item.seq  <= seq;
    end
  end

  rlsm_tracker #(
    .WINDOW_SLOTS (WINDOW_SLOTS)
  ) u_tracker (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (in_item),
    .cfg  (cfg),
    .res  (res_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res <= res_next;
    end
  end

  assign link_up         = res.link_up;
  assign quality_level   = res.quality_level;
  assign frame_age_ms    = res.frame_age_ms;
  assign was_duplicate   = res.was_duplicate;
  assign dropped_total   = res.dropped_total;
  assign duplicate_total = res.duplicate_total;
  assign resync_total    = res.resync_total;
  assign slot_tick       = res.slot_tick;

  // a held request never moves while the result stage is blocked
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("request stalled with a free result stage");

  // a processed request always produces a valid result
  assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("processed request produced no result");

  // a result waiting on a stall is held stable in the result register
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(res))
    else $error("result changed while stalled");

endmodule

`default_nettype wire
